// File: rtl/alert_table_expiry_engine_assert.svh
// Assertion macros for the alert table expiry engine.
// Used by the top level; expects clk and arst_n in scope.
`ifndef ALERT_TABLE_EXPIRY_ENGINE_ASSERT_SVH
`define ALERT_TABLE_EXPIRY_ENGINE_ASSERT_SVH

// Check that a condition holds at every edge out of reset
`define AEE_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a cause is followed by an effect in the same cycle
`define AEE_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a cause is followed by an effect in the next cycle
`define AEE_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/aee_pkg.sv
// Shared types and constants of the alert table expiry engine.
// No dependencies.
package aee_pkg;

	localparam int ALERT_COUNT_DEF = 16;
	localparam int TIME_BITS_DEF   = 48;
	localparam int ID_W            = 4;
	localparam int NOW_W           = 48;
	localparam int EXP_W           = 32;
	localparam int MASK_W          = 3;
	localparam int US_PER_MS       = 1000;
	localparam int IN_DATA_W       = 96;
	localparam int OUT_DATA_W      = 64;

	typedef enum logic [2:0] {
		CMD_REGISTER   = 3'd0,
		CMD_UNREGISTER = 3'd1,
		CMD_SET        = 3'd2,
		CMD_RESET      = 3'd3,
		CMD_POLL       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INVALID = 2'd0,
		ST_NORMAL  = 2'd1,
		ST_SET     = 2'd2,
		ST_EXPIRED = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_ALREADY = 2'd1,
		STS_NOT_REG = 2'd2
	} status_t;

	// one queued command after classification
	typedef struct packed {
		logic [2:0]        cmd;
		logic [ID_W-1:0]   id;
		logic              in_range;
		logic [NOW_W-1:0]  now_us;
		logic              auto_exp;
		logic [EXP_W-1:0]  expiry_ms;
		logic [MASK_W-1:0] notice_mask;
		logic              has_handler;
		logic              handler_accepts;
	} item_t;

	// one table entry as held in the entry RAM
	typedef struct packed {
		state_t            st;
		logic              auto_exp;
		logic [EXP_W-1:0]  expiry_ms;
		logic [MASK_W-1:0] notice_mask;
		logic              has_handler;
		logic [NOW_W-1:0]  change_time;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// front to back queue handshake
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

endpackage

// File: rtl/aee_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module aee_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/aee_front.sv
// Front end: accepts command beats, classifies the alert id, queues them.
// Depends on aee_pkg.
module aee_front import aee_pkg::*; #(
	parameter int ALERT_COUNT = ALERT_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [2:0]           s_tuser,
	output q_head_t              head,
	input  logic                 pop
);

	localparam int QD = 2;

	item_t      fifo_q [QD];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	item_t      in_item;
	logic       push;

	always_comb begin
		in_item.cmd             = s_tuser;
		in_item.id              = s_tdata[3:0];
		in_item.in_range        = (32'(s_tdata[3:0]) < ALERT_COUNT);
		in_item.now_us          = s_tdata[51:4];
		in_item.auto_exp        = s_tdata[52];
		in_item.expiry_ms       = s_tdata[84:53];
		in_item.notice_mask     = s_tdata[87:85];
		in_item.has_handler     = s_tdata[88];
		in_item.handler_accepts = s_tdata[89];
	end

	assign s_tready = (count_q != 2'(QD));
	assign push     = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = fifo_q[rd_ptr_q];

endmodule

// File: rtl/aee_back.sv
// Back end: read-modify-write of one table entry per queued command.
// Depends on aee_pkg and aee_ram.
module aee_back import aee_pkg::*; #(
	parameter int ALERT_COUNT = ALERT_COUNT_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  q_head_t               head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = (ALERT_COUNT > 1) ? $clog2(ALERT_COUNT) : 1;
	localparam int TW    = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
	localparam logic [NOW_W-1:0] TMASK = NOW_W'((65'(1) << TW) - 65'(1));

	typedef enum logic {B_IDLE, B_EXEC} bstate_t;

	bstate_t                 state_q;
	item_t                   item_s1;
	logic [ALERT_COUNT-1:0]  valid_q;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	logic [IDX_W+ID_W-1:0]   head_idw, item_idw;
	logic [IDX_W-1:0]        rd_idx, idx;
	logic [ENTRY_W-1:0]      rd_word;
	entry_t                  ent, nxt;
	logic                    wr;
	logic [1:0]              status;
	logic                    nvalid;
	logic [1:0]              nkind;
	logic [NOW_W-1:0]        ntime;
	logic [1:0]              st_out;
	logic [NOW_W-1:0]        now_m, age;
	logic [EXP_W+9:0]        limit_us;
	logic                    expire, deliver;
	logic [1:0]              kind;

	assign head_idw = (IDX_W + ID_W)'(head.item.id);
	assign item_idw = (IDX_W + ID_W)'(item_s1.id);
	assign rd_idx   = head_idw[IDX_W-1:0];
	assign idx      = item_idw[IDX_W-1:0];

	assign pop = (state_q == B_IDLE) && head.valid && (!out_valid_q || m_tready);

	// write back only in the execute cycle, the read word is stale afterwards
	aee_ram #(.WIDTH(ENTRY_W), .DEPTH(ALERT_COUNT)) u_ram (
		.clk     (clk),
		.wr_en   (wr && (state_q == B_EXEC)),
		.wr_addr (idx),
		.wr_data (nxt),
		.rd_en   (pop),
		.rd_addr (rd_idx),
		.rd_data (rd_word)
	);

	always_comb begin
		ent = rd_word;
		if (!valid_q[idx]) begin
			ent.st = ST_INVALID;
		end
		nxt      = ent;
		wr       = 1'b0;
		status   = STS_OK;
		nvalid   = 1'b0;
		nkind    = '0;
		ntime    = '0;
		now_m    = item_s1.now_us & TMASK;
		age      = (now_m - ent.change_time) & TMASK;
		// age/1000 >= expiry  <=>  age >= expiry*1000
		limit_us = (EXP_W + 10)'(ent.expiry_ms) * (EXP_W + 10)'(US_PER_MS);
		kind     = ent.st - 2'd1;
		expire   = (ent.st == ST_SET) && ent.auto_exp &&
			((EXP_W + 10 + NOW_W)'(age) >= (EXP_W + 10 + NOW_W)'(limit_us));
		deliver  = ent.notice_mask[kind] && ent.has_handler;
		if (!item_s1.in_range) begin
			status = STS_NOT_REG;
		end else if (item_s1.cmd == CMD_REGISTER) begin
			if (ent.st != ST_INVALID) begin
				status = STS_ALREADY;
			end else begin
				nxt.st          = ST_NORMAL;
				nxt.auto_exp    = item_s1.auto_exp;
				nxt.expiry_ms   = item_s1.expiry_ms;
				nxt.notice_mask = item_s1.notice_mask;
				nxt.has_handler = item_s1.has_handler;
				wr              = 1'b1;
			end
		end else if ((item_s1.cmd == CMD_UNREGISTER || item_s1.cmd == CMD_SET ||
			item_s1.cmd == CMD_RESET || item_s1.cmd == CMD_POLL) &&
			ent.st == ST_INVALID) begin
			status = STS_NOT_REG;
		end else begin
			unique case (item_s1.cmd)
				CMD_UNREGISTER: begin
					nxt.st          = ST_INVALID;
					nxt.auto_exp    = 1'b0;
					nxt.expiry_ms   = '0;
					nxt.notice_mask = '0;
					nxt.has_handler = 1'b0;
					wr              = 1'b1;
				end
				CMD_SET, CMD_RESET: begin
					nxt.st          = (item_s1.cmd == CMD_SET) ? ST_SET : ST_NORMAL;
					nxt.change_time = now_m;
					wr              = 1'b1;
				end
				CMD_POLL: begin
					if (expire) begin
						nxt.st          = ST_EXPIRED;
						nxt.change_time = now_m;
						wr              = 1'b1;
					end else if (deliver) begin
						nvalid = 1'b1;
						nkind  = kind;
						ntime  = ent.change_time;
						// an unaccepted notice keeps the old timestamp
						if (ent.st != ST_NORMAL && item_s1.handler_accepts) begin
							nxt.st          = ST_NORMAL;
							nxt.change_time = now_m;
							wr              = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		st_out = item_s1.in_range ? nxt.st : ST_INVALID;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					if (wr) begin
						valid_q[idx] <= 1'b1;
					end
					out_valid_q <= 1'b1;
					out_data_q  <= {5'd0, st_out, ntime, nkind, nvalid, item_s1.id, status};
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// File: rtl/alert_table_expiry_engine.sv
// Alert table expiry engine: register/unregister/set/reset/poll of alert entries.
// Each accepted command beat is queued, then popped into the back end, which reads the entry
// RAM, then executes and registers the result; no new pop until then, nor while the result stalls.
// A 2-deep queue decouples command intake from execution; a result register holds output.
// Reset (arst_n low, asynchronous) marks every entry invalid and empties the queue.
// Depends on aee_pkg, aee_front, aee_back, aee_ram and the assertion macro header.
`include "alert_table_expiry_engine_assert.svh"
module alert_table_expiry_engine import aee_pkg::*; #(
	parameter int ALERT_COUNT = ALERT_COUNT_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// alert_idx[3:0], now_us[51:4], auto_exp[52], expiry_ms[84:53],
	// notice_mask[87:85], has_handler[88], handler_accepts[89], zeros above
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command[2:0]
	input  logic [2:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[1:0], entry_id[5:2], notify_valid[6], notify_kind[8:7],
	// notify_time_us[56:9], next_st[58:57], zeros above
	output logic [OUT_DATA_W-1:0] m_tdata
);

	q_head_t head;
	logic    pop;

	aee_front #(.ALERT_COUNT(ALERT_COUNT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.head     (head),
		.pop      (pop)
	);

	aee_back #(.ALERT_COUNT(ALERT_COUNT), .TIME_BITS(TIME_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`AEE_CHECK(a_pop_needs_item, !pop || head.valid, "pop from empty queue")
	`AEE_IMPLIES(a_notreg_invalid, m_tvalid && m_tdata[1:0] == STS_NOT_REG,
		m_tdata[58:57] == ST_INVALID, "not-registered result with live state")
	`AEE_IMPLIES(a_quiet_no_notice, m_tvalid && !m_tdata[6],
		m_tdata[56:7] == '0, "notice fields set without notification")
	`AEE_NEXT(a_pop_spacing, pop, !pop, "back end popped on consecutive cycles")

endmodule
